[src/wlsc_pkg.sv]
// Shared constants, codes and types for the wheel lock speed classifier.
package wlsc_pkg;

    // Default width of the stored speeds
    localparam int SPEED_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int IN_WIDTH        = 16;
    localparam int BRAKE_WIDTH     = 24;
    localparam int MARGIN_WIDTH    = 16;
    localparam int STATUS_WIDTH    = 3;
    localparam int WHOLE_WIDTH     = 8;
    localparam int FRAC_BITS       = 8;
    localparam int OUT_TDATA_WIDTH = 16;
    localparam int OUT_PAD_WIDTH   = OUT_TDATA_WIDTH - STATUS_WIDTH - WHOLE_WIDTH;
    localparam int CFG_IDX_WIDTH   = 1;
    localparam int CFG_DATA_WIDTH  = 24;

    // Wheel status codes
    localparam logic [STATUS_WIDTH-1:0] ST_LOCKED = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_DECEL  = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_ACCEL  = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_CONST  = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_OTHER  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BRAKE_TERM = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MARGIN     = 1'b1;

    // Configuration reset values
    localparam logic [BRAKE_WIDTH-1:0]  BRAKE_RESET  = 24'd185196;
    localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = 16'd384;

    // Threshold unit control and status
    typedef struct packed {
        logic start;
    } thr_ctrl_t;

    typedef struct packed {
        logic busy;
        logic valid;
    } thr_stat_t;

endpackage

[src/wheel_lock_speed_classifier_core.sv]
// Top level of the wheel lock speed classifier.
//
//  Channel   Direction  Payload (low bit first)
//  s_axis    in         tdata: speed_sample[15:0]
//  m_axis    out        tdata: wheel_status[2:0], speed_whole[10:3], zeros[15:11]
//  cfg       in         index 0 brake_term[23:0], index 1 margin[15:0]
//
// The core takes no new item until the current one has passed through the bit-serial
// squarer, the radicand check and, when the radicand is not negative, the
// one-bit-per-cycle square root in the threshold unit.
// The output register frees the input side while a result waits on m_axis.
// Reset (rst_n low, asynchronous) clears the speed pair, the fill count and the
// handshakes, and restores the register defaults.
module wheel_lock_speed_classifier_core
    import wlsc_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_WIDTH-1:0]        s_axis_tdata,   // speed_sample
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata    // wheel_status, speed_whole, pad
);

    localparam int SW = SPEED_WIDTH;
    localparam int MW = ((SW > MARGIN_WIDTH) ? SW : MARGIN_WIDTH) + 1;

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_CALC = 2'b10
    } top_state_t;

    top_state_t              state_reg, state_next;
    logic [1:0]              fill_reg, fill_next;
    logic [SW-1:0]           older_reg, older_next;
    logic [SW-1:0]           newer_reg, newer_next;
    logic [WHOLE_WIDTH-1:0]  whole_reg;
    logic [BRAKE_WIDTH-1:0]  brake_reg;
    logic [MARGIN_WIDTH-1:0] margin_reg;
    logic                    out_valid_reg;
    logic [STATUS_WIDTH-1:0] out_status_reg;
    logic [WHOLE_WIDTH-1:0]  out_whole_reg;

    logic                    in_acc;
    logic [SW+IN_WIDTH-1:0]  samp_wide;
    logic [SW-1:0]           samp;
    logic [SW+IN_WIDTH-1:0]  samp_mask_wide;
    logic [WHOLE_WIDTH-1:0]  samp_whole;

    thr_ctrl_t               thr_ctrl;
    thr_stat_t               thr_stat;
    logic [SW-1:0]           thr_root;

    logic [SW:0]             half_sum;
    logic [SW-1:0]           half;
    logic [MW-1:0]           newer_plus_margin;
    logic                    below_thr;
    logic [STATUS_WIDTH-1:0] status;
    logic                    out_free;
    logic                    load_out;

    // Input handshake and sample masking
    assign s_axis_tready  = (state_reg == T_IDLE);
    assign in_acc         = s_axis_tvalid && s_axis_tready;
    assign samp_wide      = {{SW{1'b0}}, s_axis_tdata};
    assign samp           = samp_wide[SW-1:0];
    assign samp_mask_wide = {{IN_WIDTH{1'b0}}, samp};
    assign samp_whole     = samp_mask_wide[FRAC_BITS +: WHOLE_WIDTH];

    // Fill the speed pair, then shift it
    always_comb
    begin
        older_next = older_reg;
        newer_next = newer_reg;
        fill_next  = fill_reg;
        case (fill_reg)
            2'd0:
            begin
                older_next = samp;
                fill_next  = 2'd1;
            end
            2'd1:
            begin
                newer_next = samp;
                fill_next  = 2'd2;
            end
            default:
            begin
                older_next = newer_reg;
                newer_next = samp;
                fill_next  = 2'd2;
            end
        endcase
    end

    // Threshold unit works on the updated older speed
    assign thr_ctrl.start = in_acc;

    wlsc_thresh_unit #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_thresh (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (thr_ctrl),
        .operand    (older_next),
        .brake_term (brake_reg),
        .stat       (thr_stat),
        .root       (thr_root)
    );

    // Classify: newer < half - margin is tested as newer + margin < half
    assign half_sum          = {1'b0, older_reg} + {1'b0, thr_root};
    assign half              = half_sum[SW:1];
    assign newer_plus_margin = MW'(newer_reg) + MW'(margin_reg);
    assign below_thr         = newer_plus_margin < MW'(half);

    always_comb
    begin
        if (newer_reg < older_reg)
        begin
            if (!thr_stat.valid)
                status = ST_OTHER;
            else if (below_thr)
                status = ST_LOCKED;
            else
                status = ST_DECEL;
        end
        else if (newer_reg > older_reg)
        begin
            status = ST_ACCEL;
        end
        else
        begin
            status = ST_CONST;
        end
    end

    // Move the result into the output register once it is free
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load_out = (state_reg == T_CALC) && !thr_stat.busy && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_acc)
                    state_next = T_CALC;
            end
            T_CALC:
            begin
                if (load_out)
                    state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            fill_reg      <= 2'd0;
            older_reg     <= '0;
            newer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                fill_reg  <= fill_next;
                older_reg <= older_next;
                newer_reg <= newer_next;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            whole_reg <= samp_whole;
        if (load_out)
        begin
            out_status_reg <= status;
            out_whole_reg  <= whole_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_reg  <= BRAKE_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BRAKE_TERM: brake_reg  <= cfg_wr_data[BRAKE_WIDTH-1:0];
                REG_MARGIN:     margin_reg <= cfg_wr_data[MARGIN_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_WIDTH{1'b0}}, out_whole_reg, out_status_reg};

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted again while an item is in work");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("fill count out of range");

    a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_IDLE) |-> !thr_stat.busy)
        else $error("threshold unit busy while the core is idle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == ST_LOCKED || m_axis_tdata[2:0] == ST_DECEL
            || m_axis_tdata[2:0] == ST_ACCEL || m_axis_tdata[2:0] == ST_CONST
            || m_axis_tdata[2:0] == ST_OTHER))
        else $error("wheel status code out of range");

endmodule

[src/wlsc_thresh_unit.sv]
// Bit-serial squarer and square root that produce the lock threshold root.
module wlsc_thresh_unit
    import wlsc_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  thr_ctrl_t              ctrl,
    input  logic [SPEED_WIDTH-1:0] operand,
    input  logic [BRAKE_WIDTH-1:0] brake_term,
    output thr_stat_t              stat,
    output logic [SPEED_WIDTH-1:0] root
);

    localparam int SW    = SPEED_WIDTH;
    localparam int SQ_W  = 2 * SW;
    localparam int CMP_W = (SQ_W > BRAKE_WIDTH) ? SQ_W : BRAKE_WIDTH;
    localparam int CNT_W = $clog2(SW);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_SQR  = 4'b0010,
        U_CMP  = 4'b0100,
        U_ROOT = 4'b1000
    } unit_state_t;

    unit_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [SQ_W-1:0]  acc_reg;
    logic [SQ_W-1:0]  mcand_reg;
    logic [SW-1:0]    mplier_reg;
    logic [SQ_W-1:0]  rad_reg;
    logic [SW:0]      rem_reg;
    logic [SW-1:0]    root_reg;
    logic             valid_reg;

    logic [SQ_W-1:0]  sq_sum;
    logic [CMP_W:0]   diff;
    logic             rad_ok;
    logic [SW+2:0]    rem_ext;
    logic [SW+2:0]    trial;
    logic [SW+2:0]    rem_diff;
    logic             take;

    // Shift-add square step and radicand check
    assign sq_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign diff   = {1'b0, CMP_W'(acc_reg)} - {1'b0, CMP_W'(brake_term)};
    assign rad_ok = !diff[CMP_W];

    // One root bit per step: bring down two radicand bits, try root*4+1
    assign rem_ext  = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign rem_diff = rem_ext - trial;
    assign take     = !rem_diff[SW+2];

    // Sequence square, check, root
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = U_SQR;
                    cnt_next   = CNT_W'(SW - 1);
                end
            end
            U_SQR:
            begin
                if (cnt_reg == '0)
                    state_next = U_CMP;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            U_CMP:
            begin
                if (rad_ok)
                begin
                    state_next = U_ROOT;
                    cnt_next   = CNT_W'(SW - 1);
                end
                else
                begin
                    state_next = U_IDLE;
                end
            end
            U_ROOT:
            begin
                if (cnt_reg == '0)
                    state_next = U_IDLE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                if (ctrl.start)
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= SQ_W'(operand);
                    mplier_reg <= operand;
                end
            end
            U_SQR:
            begin
                acc_reg    <= sq_sum;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            U_CMP:
            begin
                valid_reg <= rad_ok;
                rad_reg   <= diff[SQ_W-1:0];
                rem_reg   <= '0;
                root_reg  <= '0;
            end
            U_ROOT:
            begin
                rem_reg  <= take ? rem_diff[SW:0] : rem_ext[SW:0];
                root_reg <= {root_reg[SW-2:0], take};
                rad_reg  <= rad_reg << 2;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.busy  = (state_reg != U_IDLE);
    assign stat.valid = valid_reg;
    assign root       = root_reg;

endmodule
